// ----- rtl/core/sxalu_pkg.sv -----
`timescale 1ns / 1ps

package sxalu_pkg;

	localparam int unsigned WORD_W = 16;

	typedef enum logic [3:0] {
		CMD_ADD = 4'd0,
		CMD_SUB = 4'd1,
		CMD_MUL = 4'd2,
		CMD_DIV = 4'd3,
		CMD_MOD = 4'd4,
		CMD_SHL = 4'd5,
		CMD_SHR = 4'd6,
		CMD_AND = 4'd7,
		CMD_BOR = 4'd8,
		CMD_XOR = 4'd9,
		CMD_IFE = 4'd10,
		CMD_IFN = 4'd11,
		CMD_IFG = 4'd12,
		CMD_IFB = 4'd13,
		CMD_SET = 4'd14
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIVIDE,
		ST_EMIT
	} alu_state_t;

	typedef struct packed {
		logic [3:0]        command;
		logic [WORD_W-1:0] value_b;
		logic [WORD_W-1:0] value_a;
	} cmd_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] result;
		logic              write_result;
		logic [WORD_W-1:0] ex_value;
		logic              write_ex;
		logic              was_skipped;
	} rsp_item_t;

	typedef struct packed {
		logic start;
		logic full;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	// one restoring step: acc = {remainder, dividend/quotient shift word}
	function automatic logic [3*WORD_W-1:0] div_step(input logic [3*WORD_W-1:0] acc,
			input logic [WORD_W-1:0] dvsr);
		logic [WORD_W:0]   trial;
		logic [WORD_W+1:0] diff;
		trial = {acc[3*WORD_W-1:2*WORD_W], acc[2*WORD_W-1]};
		diff = {1'b0, trial} - {2'b00, dvsr};
		if (!diff[WORD_W+1]) begin
			return {diff[WORD_W-1:0], acc[2*WORD_W-2:0], 1'b1};
		end else begin
			return {trial[WORD_W-1:0], acc[2*WORD_W-2:0], 1'b0};
		end
	endfunction

endpackage

// ----- rtl/core/sxalu_div.sv -----
`timescale 1ns / 1ps

module sxalu_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sxalu_pkg::div_ctl_t       ctl,
	input  logic [sxalu_pkg::WORD_W-1:0] dividend,
	input  logic [sxalu_pkg::WORD_W-1:0] divisor,
	output sxalu_pkg::div_sts_t       sts,
	output logic [2*sxalu_pkg::WORD_W-1:0] quot,
	output logic [sxalu_pkg::WORD_W-1:0]   rem
);
	import sxalu_pkg::*;

	logic [3*WORD_W-1:0] acc_q;
	logic [3*WORD_W-1:0] acc_one;
	logic [3*WORD_W-1:0] acc_two;
	logic [WORD_W-1:0]   dvsr_q;
	logic [3:0]          cnt_q;
	logic                busy_q;
	logic                done_q;

	// two quotient bits per cycle
	always_comb begin
		acc_one = div_step(acc_q, dvsr_q);
		acc_two = div_step(acc_one, dvsr_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.full ? 4'd15 : 4'd7;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q  <= {{WORD_W{1'b0}}, dividend, {WORD_W{1'b0}}};
			dvsr_q <= divisor;
		end else if (busy_q) begin
			acc_q <= acc_two;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quot     = acc_q[2*WORD_W-1:0];
	assign rem      = acc_q[3*WORD_W-1:2*WORD_W];

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> !busy_q && !done_q) else $error("divider restarted while active");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> busy_q) else $error("divider did not start");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && $past(cnt_q == 4'd0)) else $error("early divider done");

endmodule

// ----- rtl/core/sixteen_bit_alu_with_skip.sv -----
`timescale 1ns / 1ps

// Execute stage of a 16-bit processor: takes an operation with two resolved operands and
// returns the destination word, the overflow (EX) word and their write enables, one
// response per command. A failed conditional test arms a skip that suppresses the next
// command. One command is worked on at a time: after acceptance it passes through the exec
// state, then the divide state for div and mod with a nonzero divisor, then the emit state.
// Mod and div use the shared restoring divider, which retires two quotient bits per cycle:
// 16 bits for mod, 32 bits for div (integer and fractional halves).
// The response register lets a new command be accepted while the last response waits.
module sixteen_bit_alu_with_skip (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_stall,
	input  sxalu_pkg::cmd_item_t   cmd_item,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output sxalu_pkg::rsp_item_t   rsp_item
);
	import sxalu_pkg::*;

	alu_state_t        state_q;
	alu_state_t        state_d;
	logic [3:0]        op_q;
	logic [WORD_W-1:0] b_q;
	logic [WORD_W-1:0] a_q;
	logic              skip_q;
	logic              skip_d;
	rsp_item_t         rslt_q;
	rsp_item_t         rslt_d;
	logic              rslt_load;
	rsp_item_t         rsp_q;
	logic              rsp_valid_q;
	logic              rsp_load;
	logic              accept;

	rsp_item_t         exec_item;
	logic              is_test;
	logic              test_fail;
	logic [WORD_W:0]   sum;
	logic [WORD_W:0]   diff;
	logic [2*WORD_W-1:0] prod;
	logic [2*WORD_W-1:0] shl_w;
	logic [2*WORD_W-1:0] shr_w;
	logic              big_shift;
	logic              is_divmod;

	div_ctl_t            div_ctl;
	div_sts_t            div_sts;
	logic [2*WORD_W-1:0] div_quot;
	logic [WORD_W-1:0]   div_rem;

	sxalu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (b_q),
		.divisor  (a_q),
		.sts      (div_sts),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign cmd_stall = (state_q != ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign is_divmod = (op_q == CMD_DIV) || (op_q == CMD_MOD);

	always_comb begin
		sum       = {1'b0, b_q} + {1'b0, a_q};
		diff      = {1'b0, b_q} - {1'b0, a_q};
		prod      = (2*WORD_W)'(b_q) * (2*WORD_W)'(a_q);
		big_shift = |a_q[WORD_W-1:5];
		shl_w     = big_shift ? '0 : ({{WORD_W{1'b0}}, b_q} << a_q[4:0]);
		shr_w     = big_shift ? '0 : ({b_q, {WORD_W{1'b0}}} >> a_q[4:0]);
		exec_item = '0;
		is_test   = 1'b0;
		test_fail = 1'b0;
		case (cmd_t'(op_q))
			CMD_ADD: begin
				exec_item.result   = sum[WORD_W-1:0];
				exec_item.ex_value = {{(WORD_W-1){1'b0}}, sum[WORD_W]};
				exec_item.write_result = 1'b1;
				exec_item.write_ex     = 1'b1;
			end
			CMD_SUB: begin
				exec_item.result   = diff[WORD_W-1:0];
				exec_item.ex_value = {WORD_W{diff[WORD_W]}};
				exec_item.write_result = 1'b1;
				exec_item.write_ex     = 1'b1;
			end
			CMD_MUL: begin
				exec_item.result   = prod[WORD_W-1:0];
				exec_item.ex_value = prod[2*WORD_W-1:WORD_W];
				exec_item.write_result = 1'b1;
				exec_item.write_ex     = 1'b1;
			end
			CMD_DIV: begin
				exec_item.write_result = 1'b1;
				exec_item.write_ex     = 1'b1;
			end
			CMD_MOD: begin
				exec_item.write_result = 1'b1;
			end
			CMD_SHL: begin
				exec_item.result   = shl_w[WORD_W-1:0];
				exec_item.ex_value = shl_w[2*WORD_W-1:WORD_W];
				exec_item.write_result = 1'b1;
				exec_item.write_ex     = 1'b1;
			end
			CMD_SHR: begin
				exec_item.result   = shr_w[2*WORD_W-1:WORD_W];
				exec_item.ex_value = shr_w[WORD_W-1:0];
				exec_item.write_result = 1'b1;
				exec_item.write_ex     = 1'b1;
			end
			CMD_AND: begin
				exec_item.result       = b_q & a_q;
				exec_item.write_result = 1'b1;
			end
			CMD_BOR: begin
				exec_item.result       = b_q | a_q;
				exec_item.write_result = 1'b1;
			end
			CMD_XOR: begin
				exec_item.result       = b_q ^ a_q;
				exec_item.write_result = 1'b1;
			end
			CMD_IFE: begin
				is_test   = 1'b1;
				test_fail = (b_q != a_q);
			end
			CMD_IFN: begin
				is_test   = 1'b1;
				test_fail = (b_q == a_q);
			end
			CMD_IFG: begin
				is_test   = 1'b1;
				test_fail = !(b_q > a_q);
			end
			CMD_IFB: begin
				is_test   = 1'b1;
				test_fail = ((b_q & a_q) == '0);
			end
			CMD_SET: begin
				exec_item.result       = a_q;
				exec_item.write_result = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d   = state_q;
		skip_d    = skip_q;
		rslt_d    = exec_item;
		rslt_load = 1'b0;
		rsp_load  = 1'b0;
		div_ctl   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (skip_q) begin
					rslt_d             = '0;
					rslt_d.was_skipped = 1'b1;
					skip_d             = 1'b0;
					rslt_load          = 1'b1;
					state_d            = ST_EMIT;
				end else if (is_divmod && (a_q != '0)) begin
					div_ctl.start = 1'b1;
					div_ctl.full  = (op_q == CMD_DIV);
					state_d       = ST_DIVIDE;
				end else begin
					if (is_test) begin
						skip_d = test_fail;
					end
					rslt_load = 1'b1;
					state_d   = ST_EMIT;
				end
			end
			ST_DIVIDE: begin
				if (div_sts.done) begin
					rslt_d = '0;
					rslt_d.write_result = 1'b1;
					if (op_q == CMD_DIV) begin
						rslt_d.result   = div_quot[2*WORD_W-1:WORD_W];
						rslt_d.ex_value = div_quot[WORD_W-1:0];
						rslt_d.write_ex = 1'b1;
					end else begin
						rslt_d.result = div_rem;
					end
					rslt_load = 1'b1;
					state_d   = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			skip_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			skip_q  <= skip_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= cmd_item.command;
			b_q  <= cmd_item.value_b;
			a_q  <= cmd_item.value_a;
		end
		if (rslt_load) begin
			rslt_q <= rslt_d;
		end
		if (rsp_load) begin
			rsp_q <= rslt_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

	a_rsp_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_EMIT)) else $error("response without emit");
	a_skip_consumed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && skip_q) |=> !skip_q) else $error("skip not cleared");
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> state_q == ST_DIVIDE) else $error("divider done outside divide");
	a_div_start_ok: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.start |-> is_divmod && (a_q != '0) && !skip_q) else $error("bad divider start");

endmodule
